@@ hw/rtl/mpb_pkg.sv @@
// Shared types and constants for the mipmap pyramid builder and sampler.
// Request and result structs, action codes, level offset helper.
// No dependencies.
package mpb_pkg;

    // address arithmetic width; the 3-bit level field bounds the pyramid below 2^16 words
    localparam int ADDR_W = 16;

    localparam logic [1:0] ACT_LOAD   = 2'd0;
    localparam logic [1:0] ACT_BUILD  = 2'd1;
    localparam logic [1:0] ACT_SAMPLE = 2'd2;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_BUILD  = 1'b1;

    typedef struct packed {
        logic [1:0]  action;
        logic [11:0] texel_index;
        logic [31:0] texel_color;
        logic [2:0]  level;
        logic [15:0] u_frac;
        logic [15:0] v_frac;
    } req_t;

    typedef struct packed {
        logic [31:0] result_color;
        logic        result_kind;
    } rsp_t;

    // controller to datapath commands
    typedef struct packed {
        logic       load_fire;
        logic       sample_fire;
        logic       build_rd;
        logic [1:0] rd_phase;
        logic       acc_load;
        logic       acc_add;
        logic       build_wr;
        logic       build_done;
        logic [2:0] lvl;
    } mpb_cmd_t;

    // (4^L-1)/3 is the bit pattern 0101...01 with L ones
    function automatic logic [ADDR_W-1:0] level_offset(input logic [2:0] lvl);
        logic [ADDR_W-1:0] ofs;
        ofs = '0;
        for (int i = 0; i < 7; i++)
        begin
            if (i < int'(lvl))
            begin
                ofs[2*i] = 1'b1;
            end
        end
        return ofs;
    endfunction

endpackage

@@ hw/rtl/mpb_ctrl.sv @@
// Sequencer for the mipmap pyramid builder: accepts requests and walks the
// build over levels, rows, columns and the four source reads.
// Depends on mpb_pkg.
module mpb_ctrl #(
    parameter int XY_W = 5
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [1:0]        action,
    input  logic [2:0]        eff_top,
    output logic              busy,
    output mpb_pkg::mpb_cmd_t cmd,
    output logic [XY_W-1:0]   x,
    output logic [XY_W-1:0]   y
);
    import mpb_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RD   = 2'd1;
    localparam logic [1:0] ST_WR   = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]      state_reg, state_next;
    logic [1:0]      phase_reg, phase_next;
    logic [2:0]      lvl_reg, lvl_next;
    logic [XY_W-1:0] x_reg, x_next;
    logic [XY_W-1:0] y_reg, y_next;
    logic [XY_W:0]   wmax_full;
    logic [XY_W-1:0] wmax;
    logic            accept;

    assign accept    = start && (state_reg == ST_IDLE);
    assign wmax_full = ((XY_W+1)'(1) << lvl_reg) - (XY_W+1)'(1);
    assign wmax      = wmax_full[XY_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        lvl_next   = lvl_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && action == ACT_BUILD)
                begin
                    x_next     = '0;
                    y_next     = '0;
                    phase_next = '0;
                    if (eff_top == 3'd0)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        lvl_next   = eff_top - 3'd1;
                        state_next = ST_RD;
                    end
                end
            end
            ST_RD:
            begin
                phase_next = phase_reg + 2'd1;
                if (phase_reg == 2'd3)
                begin
                    state_next = ST_WR;
                end
            end
            ST_WR:
            begin
                state_next = ST_RD;
                if (x_reg == wmax)
                begin
                    x_next = '0;
                    if (y_reg == wmax)
                    begin
                        y_next = '0;
                        if (lvl_reg == 3'd0)
                        begin
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            lvl_next = lvl_reg - 3'd1;
                        end
                    end
                    else
                    begin
                        y_next = y_reg + XY_W'(1);
                    end
                end
                else
                begin
                    x_next = x_reg + XY_W'(1);
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= '0;
            lvl_reg   <= '0;
            x_reg     <= '0;
            y_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            lvl_reg   <= lvl_next;
            x_reg     <= x_next;
            y_reg     <= y_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign x    = x_reg;
    assign y    = y_reg;

    always_comb
    begin
        cmd             = '0;
        cmd.load_fire   = accept && (action == ACT_LOAD);
        cmd.sample_fire = accept && (action == ACT_SAMPLE);
        cmd.build_rd    = (state_reg == ST_RD);
        cmd.rd_phase    = phase_reg;
        cmd.acc_load    = (state_reg == ST_RD) && (phase_reg == 2'd1);
        cmd.acc_add     = (state_reg == ST_RD) && phase_reg[1];
        cmd.build_wr    = (state_reg == ST_WR);
        cmd.build_done  = (state_reg == ST_DONE);
        cmd.lvl         = lvl_reg;
    end

    // a write always follows the fourth source read
    a_wr_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.build_wr |-> $past(cmd.build_rd && cmd.rd_phase == 2'd3))
        else $error("build write without four reads");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.build_done |=> !busy)
        else $error("build done did not release busy");

    a_build_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && action == ACT_BUILD) |=> busy)
        else $error("build request not taken");

    a_xy_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> (x_reg <= wmax && y_reg <= wmax))
        else $error("build counters out of level range");

endmodule

@@ hw/rtl/mpb_datapath.sv @@
// Datapath for the mipmap pyramid: address generation, pyramid memory,
// 2x2 box filter accumulator and result register.
// Depends on mpb_pkg.
module mpb_datapath #(
    parameter int XY_W          = 5,
    parameter int PYRAMID_WORDS = 5461
) (
    input  logic              clk,
    input  logic              rst_n,
    input  mpb_pkg::mpb_cmd_t cmd,
    input  logic [XY_W-1:0]   x,
    input  logic [XY_W-1:0]   y,
    input  logic [2:0]        eff_top,
    input  mpb_pkg::req_t     request,
    output logic              result_valid,
    output mpb_pkg::rsp_t     result
);
    import mpb_pkg::*;

    localparam int MEM_AW = (PYRAMID_WORDS > 1) ? $clog2(PYRAMID_WORDS) : 1;
    localparam logic [ADDR_W-1:0] WORDS = ADDR_W'(PYRAMID_WORDS);

    logic [31:0]       mem [PYRAMID_WORDS];
    logic [31:0]       rdata_reg;
    logic              oob_reg;
    logic              samp_pend_reg;
    logic [9:0]        acc_reg  [4];
    logic [9:0]        acc_next [4];
    logic [9:0]        sum      [4];

    logic [2:0]        s_lvl;
    logic [15:0]       s_col, s_row;
    logic [ADDR_W-1:0] samp_addr;
    logic [ADDR_W-1:0] load_addr;
    logic              load_in_top;
    logic [ADDR_W-1:0] src_addr;
    logic [ADDR_W-1:0] dst_addr;
    logic [2:0]        src_lvl;

    logic              re, we;
    logic [ADDR_W-1:0] raddr, waddr;
    logic [31:0]       wdata, data_word, box_word;

    // sample address: column = u >> (16 - level), wrap is implicit
    always_comb
    begin
        s_lvl     = (request.level > eff_top) ? eff_top : request.level;
        s_col     = request.u_frac >> (5'd16 - {2'b00, s_lvl});
        s_row     = request.v_frac >> (5'd16 - {2'b00, s_lvl});
        samp_addr = level_offset(s_lvl) + (ADDR_W'(s_row) << s_lvl) + ADDR_W'(s_col);
    end

    // index must lie inside the top level
    assign load_in_top = ((ADDR_W'(request.texel_index) >> {eff_top, 1'b0}) == '0);
    assign load_addr   = level_offset(eff_top) + ADDR_W'(request.texel_index);

    // build addresses, cmd.lvl is the destination level
    always_comb
    begin
        src_lvl  = cmd.lvl + 3'd1;
        src_addr = level_offset(src_lvl)
                 + (ADDR_W'(y) << ({1'b0, cmd.lvl} + 4'd2))
                 + (ADDR_W'(x) << 1)
                 + (cmd.rd_phase[1] ? (ADDR_W'(1) << src_lvl) : '0)
                 + ADDR_W'(cmd.rd_phase[0]);
        dst_addr = level_offset(cmd.lvl) + (ADDR_W'(y) << cmd.lvl) + ADDR_W'(x);
    end

    assign data_word = oob_reg ? 32'd0 : rdata_reg;

    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            sum[c]           = acc_reg[c] + {2'b00, data_word[8*c +: 8]};
            box_word[8*c +: 8] = sum[c][9:2];
            if (cmd.acc_load)
            begin
                acc_next[c] = {2'b00, data_word[8*c +: 8]};
            end
            else if (cmd.acc_add)
            begin
                acc_next[c] = sum[c];
            end
            else
            begin
                acc_next[c] = acc_reg[c];
            end
        end
    end

    always_comb
    begin
        re    = cmd.sample_fire || cmd.build_rd;
        raddr = cmd.build_rd ? src_addr : samp_addr;
        if (cmd.build_wr)
        begin
            waddr = dst_addr;
            wdata = box_word;
            we    = (dst_addr < WORDS);
        end
        else
        begin
            waddr = load_addr;
            wdata = request.texel_color;
            we    = cmd.load_fire && load_in_top && (load_addr < WORDS);
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr[MEM_AW-1:0]] <= wdata;
        end
        if (re && raddr < WORDS)
        begin
            rdata_reg <= mem[raddr[MEM_AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            oob_reg <= (raddr >= WORDS);
        end
        for (int c = 0; c < 4; c++)
        begin
            acc_reg[c] <= acc_next[c];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            samp_pend_reg <= 1'b0;
        end
        else
        begin
            samp_pend_reg <= cmd.sample_fire;
        end
    end

    assign result_valid        = samp_pend_reg || cmd.build_done;
    assign result.result_kind  = cmd.build_done ? KIND_BUILD : KIND_SAMPLE;
    assign result.result_color = cmd.build_done ? 32'd0 : data_word;

endmodule

@@ hw/rtl/mipmap_pyramid_builder_sampler_top.sv @@
// Top level of the mipmap pyramid builder and sampler: configuration port,
// controller and datapath. Depends on mpb_pkg, mpb_ctrl, mpb_datapath.
//
//  channel   signals                          handshake
//  request   start, busy, request             taken when start && !busy
//  result    result_valid, result             one-cycle strobe, no backpressure
//  config    psel, penable, pwrite, paddr,    APB, pready tied high
//            pwdata, prdata, pready
//
// Load: busy stays low. Sample: the result follows in the next cycle from the
// registered memory read. Build: four reads on the single read port and one
// write per lower-level texel, then the done result from the done state; busy
// is high throughout.
// Reset clears the controller and sets top_size_log2 to 6; memory is not cleared.
// Results cannot be stalled and appear exactly once.
module mipmap_pyramid_builder_sampler_top #(
    parameter int MAX_LEVEL_LOG2 = 6,
    parameter int PYRAMID_WORDS  = 5461
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  mpb_pkg::req_t request,
    output logic          result_valid,
    output mpb_pkg::rsp_t result,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);
    import mpb_pkg::*;

    localparam int XY_W = (MAX_LEVEL_LOG2 > 1) ? MAX_LEVEL_LOG2 - 1 : 1;
    localparam logic [2:0] MAX_TOP = 3'(MAX_LEVEL_LOG2);

    logic [2:0]      top_reg;
    logic [2:0]      eff_top;
    mpb_cmd_t        cmd;
    logic [XY_W-1:0] x, y;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg <= 3'd6;
        end
        else if (psel && penable && pwrite && !paddr[2])
        begin
            top_reg <= pwdata[2:0];
        end
    end

    assign prdata  = paddr[2] ? 32'd0 : {29'd0, top_reg};
    assign eff_top = (top_reg > MAX_TOP) ? MAX_TOP : top_reg;

    mpb_ctrl #(
        .XY_W (XY_W)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .action  (request.action),
        .eff_top (eff_top),
        .busy    (busy),
        .cmd     (cmd),
        .x       (x),
        .y       (y)
    );

    mpb_datapath #(
        .XY_W          (XY_W),
        .PYRAMID_WORDS (PYRAMID_WORDS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .x            (x),
        .y            (y),
        .eff_top      (eff_top),
        .request      (request),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

@@ tb/sv/mipmap_pyramid_builder_sampler_top_tb.sv @@
// Self-checking testbench for mipmap_pyramid_builder_sampler_top: texel loads, pyramid
// builds and samples are checked against a behavioral copy of the texture pyramid.
// Depends on mpb_pkg and the RTL top level only.
module mipmap_pyramid_builder_sampler_top_tb;
    import mpb_pkg::*;

    localparam int          MAX_LVL       = 6;
    localparam int          PYR_WORDS     = 5461;
    localparam logic [1:0]  ACT_UNUSED    = 2'd3;
    localparam logic [2:0]  REG_TOP_SIZE  = 3'd0;
    localparam int unsigned TAIL_CYCLES   = 8;
    localparam int unsigned LIMIT_CYCLES  = 50_000_000;

    typedef enum logic { ROW_ITEM, ROW_TOP } row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic [2:0]  top;
        req_t        req;
        bit          typed;
        rsp_t        want;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    req_t        request;
    logic        result_valid;
    rsp_t        result;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // behavioral copy of the texture pyramid
    logic [31:0] pyr_words [PYR_WORDS];
    bit          pyr_known [PYR_WORDS];
    logic [2:0]  cfg_top;
    rsp_t        owed_results [$];
    int unsigned err_count;
    bit          steady;

    mipmap_pyramid_builder_sampler_top #(
        .MAX_LEVEL_LOG2 (MAX_LVL),
        .PYRAMID_WORDS  (PYR_WORDS)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .result_valid (result_valid),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #(LIMIT_CYCLES * 12);
        $display("simulation failed");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("ERROR %0t: %s got %h want %h", $time, what, got, want);
        err_count++;
    endtask

    function automatic int unsigned lvl_base(input int unsigned l);
        return ((1 << (2 * l)) - 1) / 3;
    endfunction

    function automatic int unsigned eff_top();
        return (cfg_top > MAX_LVL) ? MAX_LVL : cfg_top;
    endfunction

    function automatic int unsigned sample_addr(input logic [2:0] lvl, input logic [15:0] u,
                                                input logic [15:0] v);
        int unsigned l;
        int unsigned w;
        l = (lvl > eff_top()) ? eff_top() : lvl;
        w = 1 << l;
        return lvl_base(l) + ((v * w) >> 16) * w + ((u * w) >> 16);
    endfunction

    // per-channel truncated mean of a 2x2 block
    function automatic logic [31:0] box4(input logic [31:0] a, input logic [31:0] b,
                                         input logic [31:0] c, input logic [31:0] d);
        logic [31:0] avg;
        logic [9:0]  sum;
        for (int ch = 0; ch < 4; ch++)
        begin
            sum = 10'(a[8*ch +: 8]) + 10'(b[8*ch +: 8]) + 10'(c[8*ch +: 8])
                + 10'(d[8*ch +: 8]);
            avg[8*ch +: 8] = sum[9:2];
        end
        return avg;
    endfunction

    function automatic void store_put(input int unsigned addr, input logic [31:0] val);
        if (addr < PYR_WORDS)
        begin
            pyr_words[addr] = val;
            pyr_known[addr] = 1'b1;
        end
    endfunction

    function automatic bit level_full(input int unsigned t);
        for (int unsigned i = 0; i < (1 << (2 * t)); i++)
        begin
            if (!pyr_known[lvl_base(t) + i])
            begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    // random top texel, steered toward unwritten ones while the level is incomplete
    function automatic logic [11:0] fill_index(input int unsigned t, input bit full);
        int unsigned n;
        int unsigned idx;
        n = 1 << (2 * t);
        idx = $urandom_range(0, n - 1);
        if (!full)
        begin
            while (pyr_known[lvl_base(t) + idx])
            begin
                idx = (idx + 1) % n;
            end
        end
        return 12'(idx);
    endfunction

    task automatic pyramid_predict(input req_t r, output bit has, output rsp_t o);
        int unsigned t;
        int unsigned w;
        int unsigned src;
        int unsigned dst;
        int unsigned s;
        t = eff_top();
        has = 1'b0;
        o = '0;
        case (r.action)
            ACT_LOAD:
            begin
                if (r.texel_index < (1 << (2 * t)))
                begin
                    store_put(lvl_base(t) + r.texel_index, r.texel_color);
                end
            end
            ACT_BUILD:
            begin
                for (int l = t; l > 0; l--)
                begin
                    w = 1 << (l - 1);
                    src = lvl_base(l);
                    dst = lvl_base(l - 1);
                    for (int unsigned y = 0; y < w; y++)
                    begin
                        for (int unsigned x = 0; x < w; x++)
                        begin
                            s = src + 4 * y * w + 2 * x;
                            store_put(dst + y * w + x,
                                      box4(pyr_words[s], pyr_words[s + 1],
                                           pyr_words[s + 2 * w], pyr_words[s + 2 * w + 1]));
                        end
                    end
                end
                has = 1'b1;
                o.result_color = '0;
                o.result_kind = KIND_BUILD;
            end
            ACT_SAMPLE:
            begin
                s = sample_addr(r.level, r.u_frac, r.v_frac);
                has = 1'b1;
                o.result_color = (s < PYR_WORDS) ? pyr_words[s] : 32'h0;
                o.result_kind = KIND_SAMPLE;
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic make_item(output req_t r);
        int unsigned t;
        int unsigned pick;
        int unsigned tries;
        bit          full;
        bit          found;
        logic [2:0]  lv;
        logic [15:0] uu;
        logic [15:0] vv;
        t = eff_top();
        full = level_full(t);
        r.action = ACT_LOAD;
        r.texel_index = 12'($urandom_range(0, 4095));
        r.texel_color = $urandom;
        r.level = 3'($urandom_range(0, 7));
        r.u_frac = 16'($urandom_range(0, 65535));
        r.v_frac = 16'($urandom_range(0, 65535));
        pick = $urandom_range(0, 99);
        if (pick < 5)
        begin
            r.action = ACT_UNUSED;
        end
        else if (pick < 10)
        begin
            if (t < MAX_LVL)
            begin
                r.texel_index = 12'($urandom_range(1 << (2 * t), 4095));
            end
        end
        else if (pick < (full ? 35 : 62))
        begin
            r.texel_index = fill_index(t, full);
        end
        else if (pick < (full ? 45 : 62))
        begin
            r.action = ACT_BUILD;
        end
        else
        begin
            // only sample words that hold defined data
            found = 1'b0;
            for (tries = 0; tries < 32 && !found; tries++)
            begin
                lv = 3'($urandom_range(0, 7));
                uu = 16'($urandom_range(0, 65535));
                vv = 16'($urandom_range(0, 65535));
                found = pyr_known[sample_addr(lv, uu, vv)];
            end
            if (found)
            begin
                r.action = ACT_SAMPLE;
                r.level = lv;
                r.u_frac = uu;
                r.v_frac = vv;
            end
            else
            begin
                r.texel_index = fill_index(t, full);
            end
        end
    endtask

    // call at a rising edge; returns at the edge that accepted the request
    task automatic send_req(input req_t r, input bit typed, input rsp_t want);
        bit   taken;
        bit   has;
        rsp_t pred;
        start <= 1'b1;
        request <= r;
        do
        begin
            @(negedge clk);
            taken = !busy;
            @(posedge clk);
        end
        while (!taken);
        pyramid_predict(r, has, pred);
        if (has)
        begin
            owed_results.push_back(typed ? want : pred);
        end
    endtask

    // a one-in-five chance of dropping start for a random gap
    task automatic idle_gap();
        if (!steady && $urandom_range(0, 99) < 20)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (owed_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic apb_access(input bit wr, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        bit done;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= REG_TOP_SIZE;
        pwdata <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(negedge clk);
            done = pready;
            rdata = prdata;
            @(posedge clk);
        end
        while (!done);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic check_top_size();
        logic [31:0] rd;
        apb_access(1'b0, 32'h0, rd);
        if (rd !== {29'h0, cfg_top})
        begin
            report_mismatch("top_size_log2 readback", rd, {29'h0, cfg_top});
        end
    endtask

    task automatic set_top_size(input logic [2:0] val);
        logic [31:0] rd;
        wait_drained();
        apb_access(1'b1, {29'h0, val}, rd);
        cfg_top = val;
        check_top_size();
    endtask

    function automatic dir_row_t row_item(input logic [1:0] act, input logic [11:0] idx,
                                          input logic [31:0] color, input logic [2:0] lvl,
                                          input logic [15:0] u, input logic [15:0] v,
                                          input bit typed, input logic [31:0] want_color,
                                          input logic want_kind);
        dir_row_t row;
        row.kind = ROW_ITEM;
        row.top = '0;
        row.req.action = act;
        row.req.texel_index = idx;
        row.req.texel_color = color;
        row.req.level = lvl;
        row.req.u_frac = u;
        row.req.v_frac = v;
        row.typed = typed;
        row.want.result_color = want_color;
        row.want.result_kind = want_kind;
        return row;
    endfunction

    function automatic dir_row_t row_top(input logic [2:0] val);
        dir_row_t row;
        row = row_item(ACT_UNUSED, '0, '0, '0, '0, '0, 1'b0, '0, KIND_SAMPLE);
        row.kind = ROW_TOP;
        row.top = val;
        return row;
    endfunction

    always @(negedge clk)
    begin
        rsp_t want;
        if (rst_n && result_valid)
        begin
            if (owed_results.size() == 0)
            begin
                report_mismatch("result with none owed", result.result_color, 32'h0);
            end
            else
            begin
                want = owed_results.pop_front();
                if (result.result_color !== want.result_color)
                begin
                    report_mismatch("result_color", result.result_color, want.result_color);
                end
                if (result.result_kind !== want.result_kind)
                begin
                    report_mismatch("result_kind", 32'(result.result_kind),
                                    32'(want.result_kind));
                end
            end
        end
    end

    initial
    begin
        dir_row_t    plan [$];
        req_t        r;
        logic [2:0]  phase_top [7];
        int unsigned phase_len [7];

        phase_top = '{3'd2, 3'd7, 3'd3, 3'd0, 3'd4, 3'd1, 3'd3};
        phase_len = '{150, 150, 200, 80, 450, 80, 290};
        err_count = 0;
        steady = 1'b0;
        cfg_top = 3'd6;
        rst_n <= 1'b0;
        start <= 1'b0;
        request <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;

        // at the reset top size
        plan.push_back(row_item(ACT_LOAD, 12'd0, 32'h0000_0000, 3'd0, 16'h0, 16'h0,
                                1'b0, 32'h0, KIND_SAMPLE));
        plan.push_back(row_item(ACT_LOAD, 12'd4095, 32'hFFFF_FFFF, 3'd0, 16'h0, 16'h0,
                                1'b0, 32'h0, KIND_SAMPLE));
        plan.push_back(row_item(ACT_SAMPLE, 12'd0, 32'h0, 3'd6, 16'h0000, 16'h0000,
                                1'b1, 32'h0000_0000, KIND_SAMPLE));
        // level above the top is clamped; far corner
        plan.push_back(row_item(ACT_SAMPLE, 12'd0, 32'h0, 3'd7, 16'hFFFF, 16'hFFFF,
                                1'b1, 32'hFFFF_FFFF, KIND_SAMPLE));
        plan.push_back(row_item(ACT_UNUSED, 12'hFFF, 32'hFFFF_FFFF, 3'd7, 16'hFFFF, 16'hFFFF,
                                1'b0, 32'h0, KIND_SAMPLE));
        // single texel pyramid, out-of-range loads dropped
        plan.push_back(row_top(3'd0));
        plan.push_back(row_item(ACT_LOAD, 12'd0, 32'h1234_5678, 3'd0, 16'h0, 16'h0,
                                1'b0, 32'h0, KIND_SAMPLE));
        plan.push_back(row_item(ACT_LOAD, 12'd1, 32'hDEAD_BEEF, 3'd0, 16'h0, 16'h0,
                                1'b0, 32'h0, KIND_SAMPLE));
        plan.push_back(row_item(ACT_LOAD, 12'd4095, 32'h0, 3'd0, 16'h0, 16'h0,
                                1'b0, 32'h0, KIND_SAMPLE));
        plan.push_back(row_item(ACT_BUILD, 12'd0, 32'h0, 3'd0, 16'h0, 16'h0,
                                1'b1, 32'h0, KIND_BUILD));
        plan.push_back(row_item(ACT_SAMPLE, 12'd0, 32'h0, 3'd0, 16'h8000, 16'h8000,
                                1'b1, 32'h1234_5678, KIND_SAMPLE));
        plan.push_back(row_item(ACT_SAMPLE, 12'd0, 32'h0, 3'd5, 16'hFFFF, 16'h0001,
                                1'b1, 32'h1234_5678, KIND_SAMPLE));
        // 2x2 top: averaging truncates the low channel and keeps 0xFF
        plan.push_back(row_top(3'd1));
        for (int i = 0; i < 4; i++)
        begin
            plan.push_back(row_item(ACT_LOAD, 12'(i), (i == 3) ? 32'hFF00_FF00 : 32'hFF00_FF01,
                                    3'd0, 16'h0, 16'h0, 1'b0, 32'h0, KIND_SAMPLE));
        end
        plan.push_back(row_item(ACT_BUILD, 12'd0, 32'h0, 3'd0, 16'h0, 16'h0,
                                1'b1, 32'h0, KIND_BUILD));
        plan.push_back(row_item(ACT_SAMPLE, 12'd0, 32'h0, 3'd0, 16'h0000, 16'h0000,
                                1'b1, 32'hFF00_FF00, KIND_SAMPLE));
        plan.push_back(row_item(ACT_SAMPLE, 12'd0, 32'h0, 3'd1, 16'hFFFF, 16'hFFFF,
                                1'b1, 32'hFF00_FF00, KIND_SAMPLE));
        plan.push_back(row_item(ACT_SAMPLE, 12'd0, 32'h0, 3'd1, 16'h8000, 16'h0000,
                                1'b0, 32'h0, KIND_SAMPLE));
        plan.push_back(row_item(ACT_SAMPLE, 12'd0, 32'h0, 3'd1, 16'h7FFF, 16'h8000,
                                1'b0, 32'h0, KIND_SAMPLE));
        // register value 7 behaves as the maximum
        plan.push_back(row_top(3'd7));
        plan.push_back(row_item(ACT_LOAD, 12'd4095, 32'hA5A5_5A5A, 3'd0, 16'h0, 16'h0,
                                1'b0, 32'h0, KIND_SAMPLE));
        plan.push_back(row_item(ACT_SAMPLE, 12'd0, 32'h0, 3'd6, 16'hFFFF, 16'hFFFF,
                                1'b1, 32'hA5A5_5A5A, KIND_SAMPLE));

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        check_top_size();

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_TOP)
            begin
                set_top_size(plan[i].top);
            end
            else
            begin
                send_req(plan[i].req, plan[i].typed, plan[i].want);
                idle_gap();
            end
        end

        for (int p = 0; p < 7; p++)
        begin
            set_top_size(phase_top[p]);
            steady = (p == 4);
            for (int unsigned k = 0; k < phase_len[p]; k++)
            begin
                make_item(r);
                send_req(r, 1'b0, '0);
                if (k == phase_len[p] / 2 || $urandom_range(0, 199) == 0)
                begin
                    wait_drained();
                end
                else
                begin
                    idle_gap();
                end
            end
        end

        wait_drained();
        if (err_count == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/mpb_pkg.sv
hw/rtl/mpb_ctrl.sv
hw/rtl/mpb_datapath.sv
hw/rtl/mipmap_pyramid_builder_sampler_top.sv
tb/sv/mipmap_pyramid_builder_sampler_top_tb.sv
